FILE: design/lmlc_pkg.sv
`default_nettype none

package lmlc_pkg;

  localparam int unsigned NumRegs  = 6;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned ThrW     = 10;
  localparam int unsigned PosW     = 10;
  localparam int unsigned SpeedW   = 8;
  localparam int unsigned DutyW    = 10;
  localparam int unsigned NumPins  = 6;
  localparam int unsigned SpeedMax = 9;
  localparam int unsigned DutyIdxW = 4;

  // Configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    CFG_FOCUS_FAR  = 3'd0,
    CFG_FOCUS_NEAR = 3'd1,
    CFG_ZOOM_WIDE  = 3'd2,
    CFG_ZOOM_TELE  = 3'd3,
    CFG_IRIS_LARGE = 3'd4,
    CFG_IRIS_SMALL = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    MODE_COMMAND = 1'b0,
    MODE_SAMPLE  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    CMD_ZOOM_WIDE  = 3'd0,
    CMD_ZOOM_TELE  = 3'd1,
    CMD_FOCUS_FAR  = 3'd2,
    CMD_FOCUS_NEAR = 3'd3,
    CMD_IRIS_LARGE = 3'd4,
    CMD_IRIS_SMALL = 3'd5,
    CMD_STOP       = 3'd6,
    CMD_NONE       = 3'd7
  } cmd_t;

  // Direction pin positions
  localparam int unsigned PIN_FOCUS_A = 0;
  localparam int unsigned PIN_FOCUS_B = 1;
  localparam int unsigned PIN_ZOOM_A  = 2;
  localparam int unsigned PIN_ZOOM_B  = 3;
  localparam int unsigned PIN_IRIS_A  = 4;
  localparam int unsigned PIN_IRIS_B  = 5;

  localparam logic [ThrW-1:0] THR_HI_RESET = 10'd1023;
  localparam logic [ThrW-1:0] THR_LO_RESET = 10'd0;

  localparam logic [DutyW-1:0] DUTY_TABLE [SpeedMax+1] = '{
    10'd100, 10'd200, 10'd300, 10'd400, 10'd500,
    10'd600, 10'd700, 10'd800, 10'd900, 10'd1000
  };

  typedef logic [NumRegs-1:0][ThrW-1:0] thr_set_t;

  typedef struct packed {
    logic              mode;
    logic [2:0]        command;
    logic [SpeedW-1:0] speed;
    logic [PosW-1:0]   focus_position;
    logic [PosW-1:0]   zoom_position;
    logic [PosW-1:0]   iris_position;
  } item_t;

  typedef struct packed {
    logic [NumPins-1:0] pins;
    logic [DutyW-1:0]   focus_duty;
    logic [DutyW-1:0]   zoom_duty;
    logic [DutyW-1:0]   iris_duty;
    logic               running;
  } lens_state_t;

  typedef struct packed {
    logic               wr_en;
    logic [RegIdxW-1:0] index;
    logic [ThrW-1:0]    data;
  } cfg_wr_t;

  // Saturate speed at SpeedMax and look up the duty
  function automatic logic [DutyW-1:0] duty_for_speed(input logic [SpeedW-1:0] speed);
    logic [DutyIdxW-1:0] idx;
    if (speed > SpeedW'(SpeedMax)) begin
      idx = DutyIdxW'(SpeedMax);
    end else begin
      idx = speed[DutyIdxW-1:0];
    end
    return DUTY_TABLE[idx];
  endfunction

endpackage

`default_nettype wire

FILE: design/lmlc_ifs.sv
`default_nettype none

interface lmlc_item_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [2:0]                 command;
  logic [lmlc_pkg::SpeedW-1:0] speed;
  logic [lmlc_pkg::PosW-1:0]  focus_position;
  logic [lmlc_pkg::PosW-1:0]  zoom_position;
  logic [lmlc_pkg::PosW-1:0]  iris_position;

  modport source (output valid, mode, command, speed, focus_position, zoom_position,
                  iris_position, input ready);
  modport sink (input valid, mode, command, speed, focus_position, zoom_position,
                iris_position, output ready);
endinterface

interface lmlc_result_if;
  logic                        valid;
  logic                        ready;
  logic                        focus_a_pin;
  logic                        focus_b_pin;
  logic                        zoom_a_pin;
  logic                        zoom_b_pin;
  logic                        iris_a_pin;
  logic                        iris_b_pin;
  logic [lmlc_pkg::DutyW-1:0]  focus_duty;
  logic [lmlc_pkg::DutyW-1:0]  zoom_duty;
  logic [lmlc_pkg::DutyW-1:0]  iris_duty;
  logic                        motor_running;

  modport source (output valid, focus_a_pin, focus_b_pin, zoom_a_pin, zoom_b_pin,
                  iris_a_pin, iris_b_pin, focus_duty, zoom_duty, iris_duty,
                  motor_running, input ready);
  modport sink (input valid, focus_a_pin, focus_b_pin, zoom_a_pin, zoom_b_pin,
                iris_a_pin, iris_b_pin, focus_duty, zoom_duty, iris_duty,
                motor_running, output ready);
endinterface

interface lmlc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lmlc_pkg::RegIdxW-1:0]  index;
  logic [lmlc_pkg::ThrW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/lmlc_cfg_regs.sv
`default_nettype none

module lmlc_cfg_regs (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lmlc_pkg::cfg_wr_t  wr,
  output lmlc_pkg::thr_set_t      thr
);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr[lmlc_pkg::CFG_FOCUS_FAR]  <= lmlc_pkg::THR_HI_RESET;
      thr[lmlc_pkg::CFG_FOCUS_NEAR] <= lmlc_pkg::THR_LO_RESET;
      thr[lmlc_pkg::CFG_ZOOM_WIDE]  <= lmlc_pkg::THR_HI_RESET;
      thr[lmlc_pkg::CFG_ZOOM_TELE]  <= lmlc_pkg::THR_LO_RESET;
      thr[lmlc_pkg::CFG_IRIS_LARGE] <= lmlc_pkg::THR_HI_RESET;
      thr[lmlc_pkg::CFG_IRIS_SMALL] <= lmlc_pkg::THR_LO_RESET;
    end else if (wr.wr_en) begin
      unique case (wr.index)
        lmlc_pkg::CFG_FOCUS_FAR:  thr[lmlc_pkg::CFG_FOCUS_FAR]  <= wr.data;
        lmlc_pkg::CFG_FOCUS_NEAR: thr[lmlc_pkg::CFG_FOCUS_NEAR] <= wr.data;
        lmlc_pkg::CFG_ZOOM_WIDE:  thr[lmlc_pkg::CFG_ZOOM_WIDE]  <= wr.data;
        lmlc_pkg::CFG_ZOOM_TELE:  thr[lmlc_pkg::CFG_ZOOM_TELE]  <= wr.data;
        lmlc_pkg::CFG_IRIS_LARGE: thr[lmlc_pkg::CFG_IRIS_LARGE] <= wr.data;
        lmlc_pkg::CFG_IRIS_SMALL: thr[lmlc_pkg::CFG_IRIS_SMALL] <= wr.data;
        default: ; // unmapped index: dropped
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/lmlc_update.sv
`default_nettype none

module lmlc_update (
  input  wire lmlc_pkg::lens_state_t cur,
  input  wire lmlc_pkg::item_t       item,
  input  wire lmlc_pkg::thr_set_t    thr,
  output lmlc_pkg::lens_state_t      nxt
);

  logic [lmlc_pkg::DutyW-1:0] duty;

  assign duty = lmlc_pkg::duty_for_speed(item.speed);

  always_comb begin
    nxt = cur;
    if (item.mode == lmlc_pkg::MODE_COMMAND) begin
      unique case (item.command)
        lmlc_pkg::CMD_ZOOM_WIDE: begin
          nxt.zoom_duty = duty;
          nxt.pins[lmlc_pkg::PIN_ZOOM_A] = 1'b1;
          nxt.pins[lmlc_pkg::PIN_ZOOM_B] = 1'b0;
          nxt.running = 1'b1;
        end
        lmlc_pkg::CMD_ZOOM_TELE: begin
          nxt.zoom_duty = duty;
          nxt.pins[lmlc_pkg::PIN_ZOOM_A] = 1'b0;
          nxt.pins[lmlc_pkg::PIN_ZOOM_B] = 1'b1;
          nxt.running = 1'b1;
        end
        lmlc_pkg::CMD_FOCUS_FAR: begin
          nxt.focus_duty = duty;
          nxt.pins[lmlc_pkg::PIN_FOCUS_A] = 1'b1;
          nxt.pins[lmlc_pkg::PIN_FOCUS_B] = 1'b0;
          nxt.running = 1'b1;
        end
        lmlc_pkg::CMD_FOCUS_NEAR: begin
          nxt.focus_duty = duty;
          nxt.pins[lmlc_pkg::PIN_FOCUS_A] = 1'b0;
          nxt.pins[lmlc_pkg::PIN_FOCUS_B] = 1'b1;
          nxt.running = 1'b1;
        end
        lmlc_pkg::CMD_IRIS_LARGE: begin
          nxt.iris_duty = duty;
          nxt.pins[lmlc_pkg::PIN_IRIS_A] = 1'b1;
          nxt.pins[lmlc_pkg::PIN_IRIS_B] = 1'b0;
          nxt.running = 1'b1;
        end
        lmlc_pkg::CMD_IRIS_SMALL: begin
          nxt.iris_duty = duty;
          nxt.pins[lmlc_pkg::PIN_IRIS_A] = 1'b0;
          nxt.pins[lmlc_pkg::PIN_IRIS_B] = 1'b1;
          nxt.running = 1'b1;
        end
        lmlc_pkg::CMD_STOP: begin
          // duties are kept
          nxt.pins = '0;
          nxt.running = 1'b0;
        end
        default: ;
      endcase
    end else if (cur.running) begin
      // strict compares: a wiper sitting on a threshold clears nothing
      if (item.focus_position > thr[lmlc_pkg::CFG_FOCUS_FAR])
        nxt.pins[lmlc_pkg::PIN_FOCUS_A] = 1'b0;
      if (item.focus_position < thr[lmlc_pkg::CFG_FOCUS_NEAR])
        nxt.pins[lmlc_pkg::PIN_FOCUS_B] = 1'b0;
      if (item.zoom_position > thr[lmlc_pkg::CFG_ZOOM_WIDE])
        nxt.pins[lmlc_pkg::PIN_ZOOM_A] = 1'b0;
      if (item.zoom_position < thr[lmlc_pkg::CFG_ZOOM_TELE])
        nxt.pins[lmlc_pkg::PIN_ZOOM_B] = 1'b0;
      if (item.iris_position > thr[lmlc_pkg::CFG_IRIS_LARGE])
        nxt.pins[lmlc_pkg::PIN_IRIS_A] = 1'b0;
      if (item.iris_position < thr[lmlc_pkg::CFG_IRIS_SMALL])
        nxt.pins[lmlc_pkg::PIN_IRIS_B] = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/lens_motor_limit_controller.sv
// Channel  Dir  Fields                                            Handshake
// item     in   mode, command, speed, focus/zoom/iris_position    valid/ready
// result   out  six direction pins, three duties, motor_running   valid/ready
// cfg      in   index, data (threshold writes)                    valid/ready
//
// Each item passes an input register, then one pass through the state update
// into the result register, which loads whenever the input register advances.
// One item per cycle sustained while the result is not stalled; the motor state
// register closes the only loop. rst (synchronous) clears both stages and the
// motor state, and resets the thresholds to their defaults. A stalled result
// holds the input register; item.ready falls only then. cfg.ready is always high.
`default_nettype none

module lens_motor_limit_controller (
  input wire logic    clk,
  input wire logic    rst,
  lmlc_item_if.sink   item,
  lmlc_result_if.source result,
  lmlc_cfg_if.sink    cfg
);

  lmlc_pkg::cfg_wr_t     cfg_wr;
  lmlc_pkg::thr_set_t    thr;
  lmlc_pkg::item_t       in_item;
  logic                  in_valid;
  lmlc_pkg::lens_state_t state;
  lmlc_pkg::lens_state_t state_next;
  lmlc_pkg::lens_state_t res;
  logic                  res_valid;
  logic                  advance;

  assign cfg.ready    = 1'b1;
  assign cfg_wr.wr_en = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  lmlc_cfg_regs u_cfg (
    .clk (clk),
    .rst (rst),
    .wr  (cfg_wr),
    .thr (thr)
  );

  assign advance    = in_valid && (!res_valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item.mode           <= item.mode;
      in_item.command        <= item.command;
      in_item.speed          <= item.speed;
      in_item.focus_position <= item.focus_position;
      in_item.zoom_position  <= item.zoom_position;
      in_item.iris_position  <= item.iris_position;
    end
  end

  lmlc_update u_update (
    .cur  (state),
    .item (in_item),
    .thr  (thr),
    .nxt  (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= state_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.focus_a_pin   = res.pins[lmlc_pkg::PIN_FOCUS_A];
  assign result.focus_b_pin   = res.pins[lmlc_pkg::PIN_FOCUS_B];
  assign result.zoom_a_pin    = res.pins[lmlc_pkg::PIN_ZOOM_A];
  assign result.zoom_b_pin    = res.pins[lmlc_pkg::PIN_ZOOM_B];
  assign result.iris_a_pin    = res.pins[lmlc_pkg::PIN_IRIS_A];
  assign result.iris_b_pin    = res.pins[lmlc_pkg::PIN_IRIS_B];
  assign result.focus_duty    = res.focus_duty;
  assign result.zoom_duty     = res.zoom_duty;
  assign result.iris_duty     = res.iris_duty;
  assign result.motor_running = res.running;

endmodule

`default_nettype wire

FILE: design/lmlc_checker.sv
`default_nettype none

module lmlc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       res_valid,
  input wire logic                       res_ready,
  input wire logic [lmlc_pkg::NumPins-1:0] pins,
  input wire logic [lmlc_pkg::DutyW-1:0] focus_duty,
  input wire logic [lmlc_pkg::DutyW-1:0] zoom_duty,
  input wire logic [lmlc_pkg::DutyW-1:0] iris_duty,
  input wire logic                       motor_running
);

  localparam logic [lmlc_pkg::DutyW-1:0] DutyTop = 10'd1000;

  // a stalled result stays
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(pins) && $stable(motor_running)
      && $stable(focus_duty) && $stable(zoom_duty) && $stable(iris_duty))
    else $error("result payload changed while stalled");

  // never both directions on one motor, and no drive without the running flag
  a_pins_sane: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(pins[0] && pins[1]) && !(pins[2] && pins[3])
      && !(pins[4] && pins[5]) && (pins == '0 || motor_running))
    else $error("inconsistent direction pins");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> focus_duty <= DutyTop && zoom_duty <= DutyTop && iris_duty <= DutyTop)
    else $error("duty out of range");

endmodule

bind lens_motor_limit_controller lmlc_checker u_lmlc_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .pins          ({result.iris_b_pin, result.iris_a_pin, result.zoom_b_pin,
                   result.zoom_a_pin, result.focus_b_pin, result.focus_a_pin}),
  .focus_duty    (result.focus_duty),
  .zoom_duty     (result.zoom_duty),
  .iris_duty     (result.iris_duty),
  .motor_running (result.motor_running)
);

`default_nettype wire
